/* src/triangle_tangent_frame_assert.svh */
// Assertion macros shared by the tangent frame checker
`ifndef TRIANGLE_TANGENT_FRAME_ASSERT_SVH
`define TRIANGLE_TANGENT_FRAME_ASSERT_SVH

// same-cycle implication, sampled on clk and quiet in reset
`define TTF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tangent frame check failed");

// next-cycle implication
`define TTF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tangent frame check failed");

`endif

/* src/tf_pkg.sv */
// Types, widths and arithmetic helpers of the tangent frame pipeline
`timescale 1ns / 1ps
package tf_pkg;

	localparam int EDGE_W = 17;               // edge and uv delta width
	localparam int PROD_W = 2 * EDGE_W;       // one product of two deltas
	localparam int SUM_W = PROD_W + 1;        // numerators and determinant
	localparam int QUO_W = 32;                // quotient and result width
	localparam int FRAC_SH = 20;              // numerator scaling before division
	localparam int DIV_PRE = QUO_W - FRAC_SH; // numerator bits inside the quotient window
	localparam int MAG_W = 2 * QUO_W + 1 - 16; // cross term magnitude after the shift
	localparam int LANES = 6;                 // tangent x,y,z then bitangent x,y,z
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES = QUO_W / DIV_PER_STAGE;
	localparam int FRONT_STAGES = 4;
	localparam int BACK_STAGES = 3;
	localparam int PIPE_DEPTH = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

	typedef struct packed {
		logic signed [15:0] p0_x;
		logic signed [15:0] p0_y;
		logic signed [15:0] p0_z;
		logic signed [15:0] p1_x;
		logic signed [15:0] p1_y;
		logic signed [15:0] p1_z;
		logic signed [15:0] p2_x;
		logic signed [15:0] p2_y;
		logic signed [15:0] p2_z;
		logic [31:0] uv0_pair;
		logic [31:0] uv1_pair;
		logic [31:0] uv2_pair;
	} tf_in_t;

	typedef struct packed {
		logic signed [31:0] tan_x;
		logic signed [31:0] tan_y;
		logic signed [31:0] tan_z;
		logic signed [31:0] bitan_x;
		logic signed [31:0] bitan_y;
		logic signed [31:0] bitan_z;
		logic signed [31:0] norm_x;
		logic signed [31:0] norm_y;
		logic signed [31:0] norm_z;
		logic degenerate;
		logic saturated;
	} tf_out_t;

	// one restoring divider lane: partial remainder, dividend bits shifting
	// out at the top while quotient bits shift in at the bottom
	typedef struct packed {
		logic [SUM_W-1:0] rem;
		logic [QUO_W-1:0] word;
		logic neg;
		logic ovf;
	} tf_div_lane_t;

	typedef struct packed {
		logic sat;
		logic [QUO_W-1:0] val;
	} tf_clamp_t;

	function automatic logic [SUM_W-1:0] tf_abs(input logic signed [SUM_W-1:0] v);
		return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
	endfunction

	function automatic tf_div_lane_t tf_div_step(input tf_div_lane_t l,
			input logic [SUM_W-1:0] d);
		logic [SUM_W:0] t;
		logic ge;
		tf_div_lane_t r;
		t = {l.rem, l.word[QUO_W-1]};
		ge = (t >= {1'b0, d});
		r = l;
		r.rem = ge ? SUM_W'(t - {1'b0, d}) : SUM_W'(t);
		r.word = {l.word[QUO_W-2:0], ge};
		return r;
	endfunction

	// apply a sign to a magnitude, clamping to the signed 32-bit range
	function automatic tf_clamp_t tf_clamp(input logic neg, input logic [MAG_W-1:0] mag);
		tf_clamp_t r;
		logic [MAG_W-1:0] lim;
		lim = neg ? (MAG_W'(1) << (QUO_W - 1)) : ((MAG_W'(1) << (QUO_W - 1)) - MAG_W'(1));
		r.sat = (mag > lim);
		if (r.sat) begin
			r.val = neg ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
		end else begin
			r.val = neg ? QUO_W'(-mag[QUO_W-1:0]) : mag[QUO_W-1:0];
		end
		return r;
	endfunction

endpackage

/* src/tf_front.sv */
// Front stages: edge and uv deltas, products, numerators, magnitudes
`timescale 1ns / 1ps
module tf_front import tf_pkg::*; (
	input  logic                         clk,
	input  logic [FRONT_STAGES-1:0]      en,
	input  tf_in_t                       in_data,
	output tf_div_lane_t [LANES-1:0]     lanes,
	output logic [SUM_W-1:0]             den,
	output logic                         deg
);

	logic signed [15:0] p0 [0:2];
	logic signed [15:0] p1 [0:2];
	logic signed [15:0] p2 [0:2];
	logic signed [15:0] u0, v0, u1, v1, u2, v2;

	logic signed [EDGE_W-1:0] q1_s1 [0:2];
	logic signed [EDGE_W-1:0] q2_s1 [0:2];
	logic signed [EDGE_W-1:0] du1_s1, dv1_s1, du2_s1, dv2_s1;

	logic signed [PROD_W-1:0] ta_s2 [0:2];
	logic signed [PROD_W-1:0] tb_s2 [0:2];
	logic signed [PROD_W-1:0] ba_s2 [0:2];
	logic signed [PROD_W-1:0] bb_s2 [0:2];
	logic signed [PROD_W-1:0] da_s2, db_s2;

	logic signed [SUM_W-1:0] num_s3 [0:LANES-1];
	logic signed [SUM_W-1:0] det_s3;

	tf_div_lane_t [LANES-1:0] lane_c;
	logic [SUM_W-1:0] dmag_c;
	tf_div_lane_t [LANES-1:0] lane_s4;
	logic [SUM_W-1:0] den_s4;
	logic deg_s4;

	always_comb begin
		p0[0] = in_data.p0_x; p0[1] = in_data.p0_y; p0[2] = in_data.p0_z;
		p1[0] = in_data.p1_x; p1[1] = in_data.p1_y; p1[2] = in_data.p1_z;
		p2[0] = in_data.p2_x; p2[1] = in_data.p2_y; p2[2] = in_data.p2_z;
		u0 = $signed(in_data.uv0_pair[15:0]);
		v0 = $signed(in_data.uv0_pair[31:16]);
		u1 = $signed(in_data.uv1_pair[15:0]);
		v1 = $signed(in_data.uv1_pair[31:16]);
		u2 = $signed(in_data.uv2_pair[15:0]);
		v2 = $signed(in_data.uv2_pair[31:16]);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				q1_s1[i] <= EDGE_W'(p1[i]) - EDGE_W'(p0[i]);
				q2_s1[i] <= EDGE_W'(p2[i]) - EDGE_W'(p0[i]);
			end
			du1_s1 <= EDGE_W'(u1) - EDGE_W'(u0);
			dv1_s1 <= EDGE_W'(v1) - EDGE_W'(v0);
			du2_s1 <= EDGE_W'(u2) - EDGE_W'(u0);
			dv2_s1 <= EDGE_W'(v2) - EDGE_W'(v0);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				ta_s2[i] <= q1_s1[i] * dv2_s1;
				tb_s2[i] <= q2_s1[i] * dv1_s1;
				ba_s2[i] <= q2_s1[i] * du1_s1;
				bb_s2[i] <= q1_s1[i] * du2_s1;
			end
			da_s2 <= du1_s1 * dv2_s1;
			db_s2 <= du2_s1 * dv1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				num_s3[i]     <= SUM_W'(ta_s2[i]) - SUM_W'(tb_s2[i]);
				num_s3[3 + i] <= SUM_W'(ba_s2[i]) - SUM_W'(bb_s2[i]);
			end
			det_s3 <= SUM_W'(da_s2) - SUM_W'(db_s2);
		end
	end

	// seed each divider: the quotient overflows 32 bits exactly when
	// num * 2^20 >= det * 2^32, otherwise the top dividend bits sit below det
	always_comb begin
		logic [SUM_W-1:0] nmag;
		dmag_c = tf_abs(det_s3);
		for (int l = 0; l < LANES; l++) begin
			nmag = tf_abs(num_s3[l]);
			lane_c[l].rem  = nmag >> DIV_PRE;
			lane_c[l].word = QUO_W'({nmag, {FRAC_SH{1'b0}}});
			lane_c[l].neg  = num_s3[l][SUM_W-1] ^ det_s3[SUM_W-1];
			lane_c[l].ovf  = ({nmag, {FRAC_SH{1'b0}}} >= {dmag_c, {QUO_W{1'b0}}});
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			lane_s4 <= lane_c;
			den_s4  <= dmag_c;
			deg_s4  <= (det_s3 == '0);
		end
	end

	assign lanes = lane_s4;
	assign den   = den_s4;
	assign deg   = deg_s4;

endmodule

/* src/tf_div.sv */
// Pipelined restoring divider, six lanes sharing one divisor
`timescale 1ns / 1ps
module tf_div import tf_pkg::*; (
	input  logic                         clk,
	input  logic [DIV_STAGES-1:0]        en,
	input  tf_div_lane_t [LANES-1:0]     lanes_in,
	input  logic [SUM_W-1:0]             den_in,
	input  logic                         deg_in,
	output tf_div_lane_t [LANES-1:0]     lanes_out,
	output logic                         deg_out
);

	tf_div_lane_t [LANES-1:0] src [0:DIV_STAGES-1];
	logic [SUM_W-1:0] den_src [0:DIV_STAGES-1];
	logic deg_src [0:DIV_STAGES-1];

	tf_div_lane_t [LANES-1:0] lane_s [0:DIV_STAGES-1];
	logic [SUM_W-1:0] den_s [0:DIV_STAGES-1];
	logic deg_s [0:DIV_STAGES-1];

	assign src[0]     = lanes_in;
	assign den_src[0] = den_in;
	assign deg_src[0] = deg_in;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		tf_div_lane_t [LANES-1:0] step_c;

		if (g > 0) begin : g_link
			assign src[g]     = lane_s[g-1];
			assign den_src[g] = den_s[g-1];
			assign deg_src[g] = deg_s[g-1];
		end

		always_comb begin
			step_c = src[g];
			for (int k = 0; k < DIV_PER_STAGE; k++) begin
				for (int l = 0; l < LANES; l++) begin
					step_c[l] = tf_div_step(step_c[l], den_src[g]);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				lane_s[g] <= step_c;
				den_s[g]  <= den_src[g];
				deg_s[g]  <= deg_src[g];
			end
		end
	end

	assign lanes_out = lane_s[DIV_STAGES-1];
	assign deg_out   = deg_s[DIV_STAGES-1];

endmodule

/* src/tf_cross.sv */
// Back stages: clamp tangent and bitangent, cross product, result register
`timescale 1ns / 1ps
module tf_cross import tf_pkg::*; (
	input  logic                         clk,
	input  logic [BACK_STAGES-1:0]       en,
	input  tf_div_lane_t [LANES-1:0]     lanes,
	input  logic                         deg,
	output tf_out_t                      out_data
);

	tf_clamp_t cl_c [0:LANES-1];
	logic sat_c;

	logic signed [QUO_W-1:0] tb_s21 [0:LANES-1];
	logic sat_s21, deg_s21;

	logic signed [2*QUO_W-1:0] pm_s22 [0:2];
	logic signed [2*QUO_W-1:0] rm_s22 [0:2];
	logic signed [QUO_W-1:0] tb_s22 [0:LANES-1];
	logic sat_s22, deg_s22;

	tf_clamp_t ncl_c [0:2];
	tf_out_t out_c;
	tf_out_t out_s23;

	always_comb begin
		sat_c = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			cl_c[l] = tf_clamp(lanes[l].neg, MAG_W'(lanes[l].word));
			if (lanes[l].ovf) begin
				cl_c[l].sat = 1'b1;
				cl_c[l].val = lanes[l].neg ? {1'b1, {(QUO_W-1){1'b0}}}
					: {1'b0, {(QUO_W-1){1'b1}}};
			end
			sat_c = sat_c | cl_c[l].sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int l = 0; l < LANES; l++) begin
				tb_s21[l] <= cl_c[l].val;
			end
			sat_s21 <= sat_c;
			deg_s21 <= deg;
		end
	end

	// lanes 0..2 hold T, lanes 3..5 hold B
	always_ff @(posedge clk) begin
		if (en[1]) begin
			pm_s22[0] <= tb_s21[1] * tb_s21[5];
			rm_s22[0] <= tb_s21[2] * tb_s21[4];
			pm_s22[1] <= tb_s21[2] * tb_s21[3];
			rm_s22[1] <= tb_s21[0] * tb_s21[5];
			pm_s22[2] <= tb_s21[0] * tb_s21[4];
			rm_s22[2] <= tb_s21[1] * tb_s21[3];
			tb_s22  <= tb_s21;
			sat_s22 <= sat_s21;
			deg_s22 <= deg_s21;
		end
	end

	always_comb begin
		logic signed [2*QUO_W:0] diff;
		logic [2*QUO_W:0] mag;
		logic nsat;
		nsat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			diff = (2*QUO_W+1)'(pm_s22[i]) - (2*QUO_W+1)'(rm_s22[i]);
			mag = diff[2*QUO_W] ? (2*QUO_W+1)'(-diff) : (2*QUO_W+1)'(diff);
			ncl_c[i] = tf_clamp(diff[2*QUO_W], MAG_W'(mag >> 16));
			nsat = nsat | ncl_c[i].sat;
		end
		out_c = '0;
		if (deg_s22) begin
			out_c.degenerate = 1'b1;
		end else begin
			out_c.tan_x   = tb_s22[0];
			out_c.tan_y   = tb_s22[1];
			out_c.tan_z   = tb_s22[2];
			out_c.bitan_x = tb_s22[3];
			out_c.bitan_y = tb_s22[4];
			out_c.bitan_z = tb_s22[5];
			out_c.norm_x  = ncl_c[0].val;
			out_c.norm_y  = ncl_c[1].val;
			out_c.norm_z  = ncl_c[2].val;
			out_c.saturated = sat_s22 | nsat;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			out_s23 <= out_c;
		end
	end

	assign out_data = out_s23;

endmodule

/* src/triangle_tangent_frame.sv */
// Top level of the per-triangle tangent frame pipeline
//
// One triangle (three Q7.8 positions, three packed Q3.12 texcoords) enters on
// in_valid/in_ready; one result (tangent, bitangent and their cross product,
// all Q16.16, plus degenerate and saturated flags) leaves on
// out_valid/out_ready.
// Throughput is one triangle per clock while out_ready stays high.
// The pipeline has four front stages, sixteen divider stages at two quotient
// bits each, and three back stages for clamping, the cross-product multiply
// and the result register.
// A zero uv determinant gives all-zero vectors with degenerate set.
// Each stage holds only while the stage after it is full and held, so a
// stalled receiver freezes the result register and bubbles further up are
// squeezed out; in_ready drops only when every stage holds a transaction.
// Reset clears the stage valid bits; no result is presented until the first
// transaction has passed through.
`timescale 1ns / 1ps
module triangle_tangent_frame import tf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  tf_in_t  in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output tf_out_t out_data
);

	logic [PIPE_DEPTH-1:0] vld_q;
	logic [PIPE_DEPTH-1:0] en;

	tf_div_lane_t [LANES-1:0] front_lanes;
	tf_div_lane_t [LANES-1:0] div_lanes;
	logic [SUM_W-1:0] front_den;
	logic front_deg, div_deg;

	// a stage advances when it is empty or the one after it advances
	always_comb begin
		en[PIPE_DEPTH-1] = !vld_q[PIPE_DEPTH-1] || out_ready;
		for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < PIPE_DEPTH; k++) begin
				if (en[k]) begin
					vld_q[k] <= (k == 0) ? in_valid : vld_q[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[PIPE_DEPTH-1];

	tf_front u_front (
		.clk     (clk),
		.en      (en[FRONT_STAGES-1:0]),
		.in_data (in_data),
		.lanes   (front_lanes),
		.den     (front_den),
		.deg     (front_deg)
	);

	tf_div u_div (
		.clk       (clk),
		.en        (en[FRONT_STAGES +: DIV_STAGES]),
		.lanes_in  (front_lanes),
		.den_in    (front_den),
		.deg_in    (front_deg),
		.lanes_out (div_lanes),
		.deg_out   (div_deg)
	);

	tf_cross u_cross (
		.clk      (clk),
		.en       (en[FRONT_STAGES + DIV_STAGES +: BACK_STAGES]),
		.lanes    (div_lanes),
		.deg      (div_deg),
		.out_data (out_data)
	);

endmodule

/* src/tf_check.sv */
// Port-level checks on the tangent frame block, bound to the top level
`timescale 1ns / 1ps
`include "triangle_tangent_frame_assert.svh"
module tf_check import tf_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_ready,
	input tf_in_t  in_data,
	input logic    out_valid,
	input logic    out_ready,
	input tf_out_t out_data
);

	// a degenerate triangle carries zero vectors and no clamp flag
	`TTF_ASSERT_NOW(a_degen_zero, out_valid && out_data.degenerate, !out_data.saturated && out_data.tan_x == 0 && out_data.bitan_y == 0 && out_data.norm_z == 0)

	// with the result register empty the whole pipeline can take a transaction
	`TTF_ASSERT_NOW(a_empty_ready, !out_valid, in_ready)

	// a refused result holds
	`TTF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind triangle_tangent_frame tf_check u_tf_check (.*);
